@@ design/lgs_pkg.sv @@
// Shared types and constants for the life generation stencil.
`timescale 1ns / 1ps

package lgs_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int GRID_WIDTH_W  = 11;
    localparam int GRID_HEIGHT_W = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 1'd1;

    localparam logic [GRID_WIDTH_W-1:0]  GRID_WIDTH_RESET  = 11'd64;
    localparam logic [GRID_HEIGHT_W-1:0] GRID_HEIGHT_RESET = 16'd64;

    localparam int MIN_SIDE = 3;
    localparam int BIRTH_COUNT = 3;
    localparam int KEEP_COUNT  = 2;

    // Per-cell control that travels from the accept stage to the update stage.
    typedef struct packed {
        logic alive;
        logic start;
        logic produce;
        logic north;
        logic south;
        logic east;
        logic west;
        logic last;
    } lgs_stage_t;

    // Edge flags, bit 0 north, 1 south, 2 east, 3 west.
    typedef logic [3:0] lgs_flags_t;

endpackage

@@ design/lgs_ram.sv @@
// Generic single write port, single read port RAM with a registered read.
`timescale 1ns / 1ps

module lgs_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/life_generation_stencil.sv @@
// An accepted cell request is held in the update stage register; its result then enters the output register.
// Throughput: one cell per cycle unless results back up, set by the read-modify-write of the row store.
// The row store holds both earlier rows of each column in one RAM word; a same-column
// write and read in one cycle is forwarded around the RAM.
// Reset (rst_n, asynchronous, active low) clears position, window, flags and the fill count;
// no clearing pass is needed, so cells are taken from the first cycle after reset.
`timescale 1ns / 1ps

module life_generation_stencil #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Cell stream in.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [0] cell_alive, [7:1] zero
    input  logic                                s_axis_tuser,  // [0] start_of_grid
    // Result stream out.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata,  // [0] next_alive, [1] grow_north,
                                                               // [2] grow_south, [3] grow_east,
                                                               // [4] grow_west, [7:5] zero
    output logic                                m_axis_tlast,  // last_cell
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lgs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lgs_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // AW indexes one column of the row store; WW holds any effective width.
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = lgs_pkg::GRID_HEIGHT_W;

    // Configuration registers.
    logic [lgs_pkg::GRID_WIDTH_W-1:0]  grid_width_reg,  grid_width_next;
    logic [lgs_pkg::GRID_HEIGHT_W-1:0] grid_height_reg, grid_height_next;

    // Raster position of the next cell request.
    logic [AW-1:0] column_count_reg, column_count_next;
    logic [HW-1:0] row_count_reg,    row_count_next;

    // Number of leading row store columns that have been written since reset.
    // Columns only step by one or return to zero, so the written set is always a prefix.
    logic [WW-1:0] fill_reg, fill_next;

    // Update stage: the cell whose row store read is in flight.
    logic                stg_valid_reg,    stg_valid_next;
    lgs_pkg::lgs_stage_t stg_reg,          stg_next;
    logic [AW-1:0]       stg_col_reg,      stg_col_next;
    logic                stg_ok_reg,       stg_ok_next;
    logic                stg_fwd_reg,      stg_fwd_next;
    logic [1:0]          stg_fwd_data_reg, stg_fwd_data_next;

    logic [8:0]          window_reg, window_next;
    lgs_pkg::lgs_flags_t edge_flags_reg, edge_flags_next;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    logic                out_alive_reg, out_alive_next;
    logic                out_last_reg,  out_last_next;
    lgs_pkg::lgs_flags_t out_flags_reg, out_flags_next;

    // Effective grid size.
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    // Accept stage signals.
    logic          accept;
    logic [AW-1:0] c_pos;
    logic [HW-1:0] r_pos;
    logic [WW-1:0] c_inc;
    logic [HW:0]   r_inc;

    // Update stage signals.
    logic          stg_adv;
    logic [1:0]    rd_data;
    logic [1:0]    rows_eff;
    logic [2:0]    column_bits;
    logic [3:0]    neighbours;
    logic          birth;
    logic          alive_next;
    lgs_pkg::lgs_flags_t flags_upd;
    logic [1:0]    wr_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (grid_width_reg < lgs_pkg::GRID_WIDTH_W'(lgs_pkg::MIN_SIDE))
        begin
            w_eff = WW'(lgs_pkg::MIN_SIDE);
        end
        else if (32'(grid_width_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(grid_width_reg);
        end

        if (grid_height_reg < HW'(lgs_pkg::MIN_SIDE))
        begin
            h_eff = HW'(lgs_pkg::MIN_SIDE);
        end
        else
        begin
            h_eff = grid_height_reg;
        end
    end

    // The update stage moves on unless its result would overwrite one still waiting.
    assign stg_adv       = stg_valid_reg && (!stg_reg.produce || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !stg_valid_reg || stg_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Accept stage: resolve the raster position, flag the special rows and columns, and
    // issue the row store read for this column.
    always_comb
    begin
        c_pos = s_axis_tuser ? '0 : column_count_reg;
        r_pos = s_axis_tuser ? '0 : row_count_reg;
        // A position left beyond a shrunken grid starts over.
        if (WW'(c_pos) >= w_eff)
        begin
            c_pos = '0;
        end
        if (r_pos >= h_eff)
        begin
            r_pos = '0;
        end

        c_inc = WW'(c_pos) + WW'(1);
        r_inc = {1'b0, r_pos} + (HW + 1)'(1);

        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (accept)
        begin
            if (c_inc >= w_eff)
            begin
                column_count_next = '0;
                row_count_next    = (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[HW-1:0];
            end
            else
            begin
                column_count_next = c_inc[AW-1:0];
                row_count_next    = r_pos;
            end
        end

        stg_next.alive   = s_axis_tdata[0];
        stg_next.start   = s_axis_tuser;
        stg_next.produce = (r_pos >= HW'(2)) && (c_pos >= AW'(2));
        stg_next.north   = (r_pos == h_eff - HW'(1));
        stg_next.south   = (r_pos == HW'(2));
        stg_next.east    = (WW'(c_pos) == w_eff - WW'(1));
        stg_next.west    = (c_pos == AW'(2));
        stg_next.last    = stg_next.north && stg_next.east;
        stg_col_next     = c_pos;
        // Columns never written since reset read as dead.
        stg_ok_next      = (WW'(c_pos) < fill_reg);
        // The update stage writes this same column at this edge: take its data directly.
        stg_fwd_next      = stg_adv && (stg_col_reg == c_pos);
        stg_fwd_data_next = wr_data;

        if (accept)
        begin
            stg_valid_next = 1'b1;
        end
        else if (stg_adv)
        begin
            stg_valid_next = 1'b0;
        end
        else
        begin
            stg_valid_next = stg_valid_reg;
        end
    end

    // Row store word: bit 0 the row above, bit 1 the row two above.
    lgs_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .clk   (clk),
        .we    (stg_adv),
        .waddr (stg_col_reg),
        .wdata (wr_data),
        .re    (accept),
        .raddr (c_pos),
        .rdata (rd_data)
    );

    // Update stage: shift the window, count neighbours, write the column back, set flags and output.
    always_comb
    begin
        if (stg_fwd_reg)
        begin
            rows_eff = stg_fwd_data_reg;
        end
        else if (stg_ok_reg)
        begin
            rows_eff = rd_data;
        end
        else
        begin
            rows_eff = 2'b00;
        end

        // The cell above moves down to two above, and the new cell becomes the row above.
        wr_data = {rows_eff[0], stg_reg.alive};

        column_bits = {stg_reg.alive, rows_eff[0], rows_eff[1]};
        window_next = stg_adv ? {column_bits, window_reg[8:3]} : window_reg;

        neighbours = 4'(window_next[0]) + 4'(window_next[1]) + 4'(window_next[2])
                   + 4'(window_next[3]) + 4'(window_next[5]) + 4'(window_next[6])
                   + 4'(window_next[7]) + 4'(window_next[8]);
        birth      = (neighbours == 4'(lgs_pkg::BIRTH_COUNT));
        alive_next = birth || ((neighbours == 4'(lgs_pkg::KEEP_COUNT)) && window_next[4]);

        // A start cell clears the flags before its own count can set them.
        flags_upd = stg_reg.start ? '0 : edge_flags_reg;
        if (stg_reg.produce && birth)
        begin
            flags_upd = flags_upd | {stg_reg.west, stg_reg.east, stg_reg.south, stg_reg.north};
        end

        edge_flags_next = edge_flags_reg;
        if (stg_adv)
        begin
            edge_flags_next = (stg_reg.produce && stg_reg.last) ? '0 : flags_upd;
        end

        fill_next = fill_reg;
        if (stg_adv && (WW'(stg_col_reg) == fill_reg))
        begin
            fill_next = fill_reg + WW'(1);
        end

        out_alive_next = out_alive_reg;
        out_last_next  = out_last_reg;
        out_flags_next = out_flags_reg;
        if (stg_adv && stg_reg.produce)
        begin
            out_valid_next = 1'b1;
            out_alive_next = alive_next;
            out_last_next  = stg_reg.last;
            out_flags_next = stg_reg.last ? flags_upd : '0;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_comb
    begin
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lgs_pkg::REG_GRID_WIDTH:
                begin
                    grid_width_next = cfg_data[lgs_pkg::GRID_WIDTH_W-1:0];
                end
                lgs_pkg::REG_GRID_HEIGHT:
                begin
                    grid_height_next = cfg_data[lgs_pkg::GRID_HEIGHT_W-1:0];
                end
                default:
                begin
                    grid_width_next = grid_width_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg   <= lgs_pkg::GRID_WIDTH_RESET;
            grid_height_reg  <= lgs_pkg::GRID_HEIGHT_RESET;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            fill_reg         <= '0;
            stg_valid_reg    <= 1'b0;
            stg_fwd_reg      <= 1'b0;
            window_reg       <= '0;
            edge_flags_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            grid_width_reg   <= grid_width_next;
            grid_height_reg  <= grid_height_next;
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            fill_reg         <= fill_next;
            stg_valid_reg    <= stg_valid_next;
            if (accept)
            begin
                stg_fwd_reg <= stg_fwd_next;
            end
            window_reg       <= window_next;
            edge_flags_reg   <= edge_flags_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_reg          <= stg_next;
            stg_col_reg      <= stg_col_next;
            stg_ok_reg       <= stg_ok_next;
            stg_fwd_data_reg <= stg_fwd_data_next;
        end
        out_alive_reg <= out_alive_next;
        out_last_reg  <= out_last_next;
        out_flags_reg <= out_flags_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_flags_reg, out_alive_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

@@ verif/tb_life_generation_stencil.sv @@
// Self-checking testbench for the life generation stencil, with its own generation predictor.
`timescale 1ns / 1ps

module tb_life_generation_stencil;

    localparam int          GRID_MAX    = 1024;  // row store depth of the block under test
    localparam int          CLK_HALF    = 10;    // 20 ns clock period
    localparam int          RESET_TICKS = 3;
    localparam int unsigned SETTLE      = 4;     // idle margin after the last result is back
    localparam int unsigned STALL_LIMIT = 2000;  // cycles with no handshake before giving up
    localparam int unsigned SMALL_CELLS = 360;   // random cells sent on small grids
    localparam int unsigned OPEN_CELLS  = 32;    // cells sent into a pass that is left open

    // Directed 3x3 grids in raster order, bit 0 first. The top row alone gives the
    // centre exactly three neighbours, so it is born and every edge flag sets. The
    // diagonal leaves a live centre with two neighbours, so it survives.
    localparam bit [8:0] TOP_ROW  = 9'b000_000_111;
    localparam bit [8:0] DIAGONAL = 9'b100_010_001;

    // One expected result, as the block should report it.
    typedef struct packed {
        bit next_alive;
        bit last_cell;
        bit grow_north;
        bit grow_south;
        bit grow_east;
        bit grow_west;
    } gen_result_t;

    // Predicts one generation from the accepted cell stream and checks the results
    // in order against it.
    class generation_board;
        bit [lgs_pkg::GRID_WIDTH_W-1:0]  width_reg;
        bit [lgs_pkg::GRID_HEIGHT_W-1:0] height_reg;
        bit                     row_above[GRID_MAX];
        bit                     row_above2[GRID_MAX];
        bit [8:0]               window;
        int unsigned            col_pos;
        int unsigned            row_pos;
        bit [3:0]               grow_flags;  // bit 0 north, 1 south, 2 east, 3 west
        gen_result_t            pending[$];
        int unsigned            cells_taken;
        int unsigned            results_checked;
        int unsigned            failures;

        function new();
            width_reg       = lgs_pkg::GRID_WIDTH_RESET;
            height_reg      = lgs_pkg::GRID_HEIGHT_RESET;
            window          = '0;
            col_pos         = 0;
            row_pos         = 0;
            grow_flags      = '0;
            cells_taken     = 0;
            results_checked = 0;
            failures        = 0;
        endfunction

        function int unsigned active_width();
            if (width_reg < lgs_pkg::MIN_SIDE)
                return lgs_pkg::MIN_SIDE;
            if (width_reg > GRID_MAX)
                return GRID_MAX;
            return width_reg;
        endfunction

        function int unsigned active_height();
            if (height_reg < lgs_pkg::MIN_SIDE)
                return lgs_pkg::MIN_SIDE;
            return height_reg;
        endfunction

        function void write_reg(logic [lgs_pkg::CFG_INDEX_W-1:0] index,
                                logic [lgs_pkg::CFG_DATA_W-1:0] value);
            if (index == lgs_pkg::REG_GRID_WIDTH)
                width_reg = value[lgs_pkg::GRID_WIDTH_W-1:0];
            else if (index == lgs_pkg::REG_GRID_HEIGHT)
                height_reg = value[lgs_pkg::GRID_HEIGHT_W-1:0];
        endfunction

        // Notes one accepted cell and queues the result it causes, if any.
        function void take_cell(bit cell_bit, bit start);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            int unsigned neighbours;
            bit          centre;
            gen_result_t res;
            w = active_width();
            h = active_height();
            cells_taken++;
            if (start)
            begin
                col_pos    = 0;
                row_pos    = 0;
                grow_flags = '0;
            end
            // A size written mid-pass can leave the position outside the grid.
            if (col_pos >= w)
                col_pos = 0;
            if (row_pos >= h)
                row_pos = 0;
            c = col_pos;
            r = row_pos;
            window = {cell_bit, row_above[c], row_above2[c], window[8:3]};
            row_above2[c] = row_above[c];
            row_above[c]  = cell_bit;
            if (r >= 2 && c >= 2)
            begin
                centre     = window[4];
                neighbours = $countones(window) - centre;
                res        = '0;
                if (neighbours == lgs_pkg::BIRTH_COUNT)
                begin
                    res.next_alive = 1'b1;
                    if (r == h - 1)
                        grow_flags[0] = 1'b1;
                    if (r == 2)
                        grow_flags[1] = 1'b1;
                    if (c == w - 1)
                        grow_flags[2] = 1'b1;
                    if (c == 2)
                        grow_flags[3] = 1'b1;
                end
                else if (neighbours == lgs_pkg::KEEP_COUNT)
                    res.next_alive = centre;
                res.last_cell = (r == h - 1) && (c == w - 1);
                if (res.last_cell)
                begin
                    {res.grow_west, res.grow_east, res.grow_south, res.grow_north} = grow_flags;
                    grow_flags = '0;
                end
                pending.push_back(res);
            end
            col_pos = c + 1;
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos = r + 1;
                if (row_pos >= h)
                    row_pos = 0;
            end
        endfunction

        function void match_field(string field, logic [2:0] want, logic [2:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                failures++;
            end
        endfunction

        // Checks one accepted result against the oldest prediction.
        function void check_result(logic [7:0] data, logic last);
            gen_result_t want;
            results_checked++;
            if (pending.size() == 0)
            begin
                $error("result with no cell pending: tdata %h, tlast %b", data, last);
                failures++;
                return;
            end
            want = pending.pop_front();
            match_field("next_alive", 3'(want.next_alive), 3'(data[0]));
            match_field("last_cell", 3'(want.last_cell), 3'(last));
            match_field("grow_north", 3'(want.grow_north), 3'(data[1]));
            match_field("grow_south", 3'(want.grow_south), 3'(data[2]));
            match_field("grow_east", 3'(want.grow_east), 3'(data[3]));
            match_field("grow_west", 3'(want.grow_west), 3'(data[4]));
            match_field("tdata padding", 3'd0, data[7:5]);
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;   // [0] cell_alive, [7:1] zero
    logic                   s_axis_tuser;   // [0] start_of_grid
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [7:0]             m_axis_tdata;   // [0] next_alive, [1] grow_north, [2] grow_south,
                                            // [3] grow_east, [4] grow_west, [7:5] zero
    logic                   m_axis_tlast;   // last_cell
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [lgs_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [lgs_pkg::CFG_DATA_W-1:0]  cfg_data;

    generation_board board;
    int unsigned     send_idle_pct;
    int unsigned     take_idle_pct;
    int unsigned     size_settings;

    life_generation_stencil #(
        .MAX_WIDTH(GRID_MAX)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Gap length for either side: none at all outside the chosen share of requests,
    // otherwise mostly short, and now and then a long stretch.
    function automatic int unsigned pick_gap(int unsigned pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Sends one cell request after an optional gap. Inputs move only at the falling
    // edge; the handshake is sampled at the rising edge, where the block's registered
    // outputs still hold their pre-edge values.
    task automatic send_cell(bit cell_bit, bit start, int unsigned gap);
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {7'd0, 1'($urandom_range(0, 1))};
            s_axis_tuser  <= 1'($urandom_range(0, 1));
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, cell_bit};
        s_axis_tuser  <= start;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.take_cell(cell_bit, start);
    endtask

    // Writes one register; only called while the block has nothing in flight.
    task automatic write_reg(logic [lgs_pkg::CFG_INDEX_W-1:0] index,
                             logic [lgs_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.write_reg(index, value);
        size_settings++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Holds the cell stream until every predicted result has come back, then lets
    // the given number of extra cycles pass.
    task automatic wait_results(int unsigned settle);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // One whole grid of random content. Most grids keep the outer ring dead as a real
    // pass would; some put a stray start request somewhere inside, and some pause the
    // stream halfway until the results have caught up.
    task automatic send_grid(int unsigned w, int unsigned h, int unsigned density,
                             bit dead_ring, bit first_start);
        int unsigned r;
        int unsigned c;
        int unsigned stray_start;
        int unsigned pause_at;
        bit          cell_bit;
        bit          border;
        stray_start = ($urandom_range(0, 7) == 0) ? $urandom_range(1, w * h - 1) : 0;
        pause_at    = ($urandom_range(0, 5) == 0) ? $urandom_range(1, w * h - 1) : 0;
        for (r = 0; r < h; r++)
        begin
            for (c = 0; c < w; c++)
            begin
                border   = (r == 0) || (c == 0) || (r == h - 1) || (c == w - 1);
                cell_bit = (border && dead_ring) ? 1'b0 : ($urandom_range(0, 99) < density);
                if (pause_at != 0 && r * w + c == pause_at)
                    wait_results(0);
                send_cell(cell_bit,
                          (r == 0 && c == 0) ? first_start : (r * w + c == stray_start),
                          pick_gap(send_idle_pct));
            end
        end
    endtask

    // Result side: the ready line drops for random stretches of its own.
    initial
    begin : result_sink
        int unsigned hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold != 0)
            begin
                m_axis_tready <= 1'b0;
                hold--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                hold = pick_gap(take_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tlast);
    end

    // Ends the run if no request of any kind is accepted for too long.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_life_generation_stencil: errors");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned i;
        int unsigned phase;
        int unsigned small_cells;
        int unsigned width_set;
        int unsigned height_set;
        int unsigned grids;
        int unsigned w;
        int unsigned h;
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = lgs_pkg::REG_GRID_WIDTH;
        cfg_data      = '0;
        board         = new();
        send_idle_pct = 0;
        take_idle_pct = 0;
        size_settings = 0;
        small_cells   = 0;

        repeat (RESET_TICKS) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: both sizes written below the minimum, so the smallest 3x3
        // grid applies. The first grid gives a birth in a single interior cell that
        // is first and last in both directions, so all four flags report. The second
        // follows with no start request and relies on the position wrapping.
        write_reg(lgs_pkg::REG_GRID_WIDTH, lgs_pkg::CFG_DATA_W'(0));
        write_reg(lgs_pkg::REG_GRID_HEIGHT, lgs_pkg::CFG_DATA_W'(2));
        for (i = 0; i < 9; i++)
            send_cell(TOP_ROW[i], i == 0, 0);
        for (i = 0; i < 9; i++)
            send_cell(DIAGONAL[i], 1'b0, 0);
        wait_results(SETTLE);

        // Random phases. Each one picks a size, writes it while the block is idle and
        // sends a few grids. Two phases set the size extremes instead and leave a short
        // pass open, so that any following phase changes the size mid-pass.
        phase = 0;
        while ((small_cells < SMALL_CELLS) || (phase <= 4))
        begin
            wait_results(SETTLE);
            send_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
            take_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
            case (phase)
                2:
                begin
                    // Full width and the tallest grid: only the start of the first row
                    // is sent, and the next phase changes the size while the pass is open.
                    write_reg(lgs_pkg::REG_GRID_WIDTH, lgs_pkg::CFG_DATA_W'(GRID_MAX));
                    write_reg(lgs_pkg::REG_GRID_HEIGHT, lgs_pkg::CFG_DATA_W'(16'hFFFF));
                    for (i = 0; i < OPEN_CELLS; i++)
                        send_cell($urandom_range(0, 2) == 0, i == 0, pick_gap(send_idle_pct));
                end
                4:
                begin
                    // A width beyond the row store is clamped; this pass is left open too.
                    write_reg(lgs_pkg::REG_GRID_WIDTH, lgs_pkg::CFG_DATA_W'(2047));
                    write_reg(lgs_pkg::REG_GRID_HEIGHT, lgs_pkg::CFG_DATA_W'(lgs_pkg::MIN_SIDE));
                    for (i = 0; i < OPEN_CELLS; i++)
                        send_cell($urandom_range(0, 1) == 1, i == 0, pick_gap(send_idle_pct));
                end
                default:
                begin
                    case ($urandom_range(0, 5))
                        0:       width_set = $urandom_range(0, 2);
                        1:       width_set = lgs_pkg::MIN_SIDE;
                        default: width_set = $urandom_range(4, 10);
                    endcase
                    case ($urandom_range(0, 5))
                        0:       height_set = $urandom_range(0, 2);
                        1:       height_set = lgs_pkg::MIN_SIDE;
                        default: height_set = $urandom_range(4, 8);
                    endcase
                    // Bits above the width register ride along and must be dropped.
                    write_reg(lgs_pkg::REG_GRID_WIDTH,
                              lgs_pkg::CFG_DATA_W'(($urandom_range(0, 31)
                                                    << lgs_pkg::GRID_WIDTH_W) | width_set));
                    write_reg(lgs_pkg::REG_GRID_HEIGHT, lgs_pkg::CFG_DATA_W'(height_set));
                    w     = board.active_width();
                    h     = board.active_height();
                    grids = $urandom_range(1, 3);
                    for (i = 0; i < grids; i++)
                    begin
                        send_grid(w, h, 10 + 25 * $urandom_range(0, 2),
                                  $urandom_range(0, 6) != 0, $urandom_range(0, 4) != 0);
                        small_cells += w * h;
                    end
                end
            endcase
            phase++;
        end

        wait_results(SETTLE);
        if (board.pending.size() != 0)
        begin
            $error("%0d results never arrived", board.pending.size());
            board.failures++;
        end
        $display("Sent %0d cells and checked %0d results over %0d register writes,",
                 board.cells_taken, board.results_checked, size_settings);
        $display("covering undersized and small random grids and open widest and tallest passes.");
        if (board.failures == 0)
            $display("tb_life_generation_stencil: clean");
        else
            $display("tb_life_generation_stencil: errors");
        $finish;
    end

endmodule

@@ files.f @@
design/lgs_pkg.sv
design/lgs_ram.sv
design/life_generation_stencil.sv
verif/tb_life_generation_stencil.sv
